/* rtl/core/pbf_pkg.sv */
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared constants, codes and request/response types for the byte pipe.
// ----------------------------------------------------------------------------
package pbf_pkg;

    localparam int DEPTH     = 4096;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int FILL_W    = 13;
    localparam int OPEN_W    = 8;

    localparam logic [OPEN_W-1:0] OPEN_MAX = '1;

    localparam logic [2:0] FUNC_WRITE    = 3'd0;
    localparam logic [2:0] FUNC_READ     = 3'd1;
    localparam logic [2:0] FUNC_OPEN     = 3'd2;
    localparam logic [2:0] FUNC_CLOSE    = 3'd3;
    localparam logic [2:0] FUNC_SHUTDOWN = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BLOCK  = 2'd1;
    localparam logic [1:0] ST_BROKEN = 2'd2;
    localparam logic [1:0] ST_EOD    = 2'd3;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] write_byte;
        logic       end_is_read;
        logic       last;
    } req_t;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [PTR_W-1:0] addr;
        logic [7:0]       wdata;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              last;
        logic              rd_ok;
        logic [FILL_W-1:0] fill;
    } rsp_t;

endpackage

/* rtl/core/pbf_ram.sv */
// ----------------------------------------------------------------------------
// pbf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/pbf_ctrl.sv */
// ----------------------------------------------------------------------------
// pbf_ctrl
// Pipe state: pointers, fill count, endpoint counts and shutdown flag.
// Decides the outcome of one request and drives the buffer access.
// ----------------------------------------------------------------------------
module pbf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  pbf_pkg::req_t    req,
    output pbf_pkg::mem_req_t mem_req,
    output pbf_pkg::rsp_t    rsp
);

    logic [pbf_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [pbf_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [pbf_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [pbf_pkg::OPEN_W-1:0] readers_reg, readers_next;
    logic [pbf_pkg::OPEN_W-1:0] writers_reg, writers_next;
    logic                       shut_reg, shut_next;
    logic [31:0]                count_wide;

    localparam logic [pbf_pkg::PTR_W-1:0] PTR_LAST = pbf_pkg::PTR_W'(pbf_pkg::DEPTH - 1);
    localparam logic [pbf_pkg::CNT_W-1:0] CNT_FULL = pbf_pkg::CNT_W'(pbf_pkg::DEPTH);

    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        count_next   = count_reg;
        readers_next = readers_reg;
        writers_next = writers_reg;
        shut_next    = shut_reg;
        mem_req      = '0;
        rsp.status   = pbf_pkg::ST_OK;
        rsp.last     = req.last;
        rsp.rd_ok    = 1'b0;

        if (req_valid)
        begin
            case (req.func)
                pbf_pkg::FUNC_WRITE:
                begin
                    if (shut_reg || (readers_reg == '0))
                    begin
                        rsp.status = pbf_pkg::ST_BROKEN;
                    end
                    else if (count_reg >= CNT_FULL)
                    begin
                        rsp.status = pbf_pkg::ST_BLOCK;
                    end
                    else
                    begin
                        mem_req.en    = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.addr  = wr_ptr_reg;
                        mem_req.wdata = req.write_byte;
                        wr_ptr_next   = (wr_ptr_reg == PTR_LAST) ? '0
                                                                 : wr_ptr_reg + 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                pbf_pkg::FUNC_READ:
                begin
                    if (count_reg != '0)
                    begin
                        mem_req.en   = 1'b1;
                        mem_req.addr = rd_ptr_reg;
                        rsp.rd_ok    = 1'b1;
                        rd_ptr_next  = (rd_ptr_reg == PTR_LAST) ? '0
                                                                : rd_ptr_reg + 1'b1;
                        count_next   = count_reg - 1'b1;
                    end
                    else if ((writers_reg != '0) && !shut_reg)
                    begin
                        rsp.status = pbf_pkg::ST_BLOCK;
                    end
                    else
                    begin
                        rsp.status = pbf_pkg::ST_EOD;
                    end
                end
                pbf_pkg::FUNC_OPEN:
                begin
                    if (req.end_is_read)
                    begin
                        if (readers_reg != pbf_pkg::OPEN_MAX)
                        begin
                            readers_next = readers_reg + 1'b1;
                        end
                    end
                    else if (writers_reg != pbf_pkg::OPEN_MAX)
                    begin
                        writers_next = writers_reg + 1'b1;
                    end
                end
                pbf_pkg::FUNC_CLOSE:
                begin
                    if (req.end_is_read)
                    begin
                        if (readers_reg != '0)
                        begin
                            readers_next = readers_reg - 1'b1;
                        end
                    end
                    else if (writers_reg != '0)
                    begin
                        writers_next = writers_reg - 1'b1;
                    end
                    if ((readers_next == '0) && (writers_next == '0))
                    begin
                        shut_next = 1'b1;
                    end
                end
                pbf_pkg::FUNC_SHUTDOWN:
                begin
                    shut_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        count_wide = 32'(count_next);
        rsp.fill   = count_wide[pbf_pkg::FILL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            count_reg   <= '0;
            readers_reg <= '0;
            writers_reg <= '0;
            shut_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            count_reg   <= count_next;
            readers_reg <= readers_next;
            writers_reg <= writers_next;
            shut_reg    <= shut_next;
        end
    end

endmodule

/* rtl/core/pipe_byte_fifo_core.sv */
// ----------------------------------------------------------------------------
// pipe_byte_fifo_core
// A result strobes on done once its request has passed the request register
// and the done register. Throughput: one request per cycle; busy stays low,
// the receiver never stalls. The RAM's registered read data lines up with done.
// Reset clears pointers, counts and the shutdown flag; buffer contents are
// left as they were and are never returned before being written.
// ----------------------------------------------------------------------------
module pipe_byte_fifo_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 func,
    input  logic [7:0]                 write_byte,
    input  logic                       end_is_read,
    input  logic                       last_in_call,
    output logic                       done,
    output logic [7:0]                 read_byte,
    output logic [1:0]                 status,
    output logic                       last,
    output logic [pbf_pkg::FILL_W-1:0] fill_level
);

    logic              req_valid_reg;
    pbf_pkg::req_t     req_reg;
    pbf_pkg::mem_req_t mem_req;
    pbf_pkg::rsp_t     rsp;
    pbf_pkg::rsp_t     rsp_reg;
    logic              done_reg;
    logic [7:0]        ram_rdata;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= '{func: func, write_byte: write_byte,
                     end_is_read: end_is_read, last: last_in_call};
        rsp_reg <= rsp;
    end

    pbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid_reg),
        .req       (req_reg),
        .mem_req   (mem_req),
        .rsp       (rsp)
    );

    pbf_ram #(
        .WIDTH (8),
        .DEPTH (pbf_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (ram_rdata)
    );

    assign done       = done_reg;
    assign read_byte  = rsp_reg.rd_ok ? ram_rdata : 8'd0;
    assign status     = rsp_reg.status;
    assign last       = rsp_reg.last;
    assign fill_level = rsp_reg.fill;

`ifndef SYNTH
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request without result two cycles later");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(fill_level) <= 32'(pbf_pkg::DEPTH)))
        else $error("fill level beyond buffer depth");

    a_byte_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != pbf_pkg::ST_OK)) |-> (read_byte == 8'd0))
        else $error("read byte on failed request");

    a_no_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start && !busy, 2) |-> !done)
        else $error("result without request");
`endif

endmodule

/* dv/pipe_byte_fifo_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipe_byte_fifo_core_tb
// Self-checking bench for the byte pipe. Requests come from a queue filled up
// front: a short directed opening, random read/write calls and endpoint
// traffic under three idle patterns, reader count saturation, and a closing
// shutdown sequence. A behavioral copy of the pipe predicts every response,
// and each done strobe is checked against it in order.
// ----------------------------------------------------------------------------
module pipe_byte_fifo_core_tb;
    import pbf_pkg::*;

    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
    localparam int RAND_PER_PHASE = 100;
    localparam int WDOG_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PRINT_LIMIT    = 40;
    localparam int FINAL_READS    = 48;

    typedef struct {
        logic [2:0] func;
        logic [7:0] write_byte;
        logic       end_is_read;
        logic       last;
        int         gap_pct;
    } pipe_req_t;

    typedef struct packed {
        logic [7:0]        read_byte;
        logic [1:0]        status;
        logic              last;
        logic [FILL_W-1:0] fill;
    } pipe_rsp_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic [2:0]        func        = FUNC_WRITE;
    logic [7:0]        write_byte  = '0;
    logic              end_is_read = 1'b0;
    logic              last_in_call = 1'b0;
    logic              busy;
    logic              done;
    logic [7:0]        read_byte;
    logic [1:0]        status;
    logic              last;
    logic [FILL_W-1:0] fill_level;

    pipe_byte_fifo_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .write_byte   (write_byte),
        .end_is_read  (end_is_read),
        .last_in_call (last_in_call),
        .done         (done),
        .read_byte    (read_byte),
        .status       (status),
        .last         (last),
        .fill_level   (fill_level)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Pipe prediction
    // ------------------------------------------------------------------------
    logic [7:0]        buf_mem [DEPTH];
    logic [PTR_W-1:0]  head_ptr   = '0;
    logic [PTR_W-1:0]  tail_ptr   = '0;
    int                held_bytes = 0;
    logic [OPEN_W-1:0] n_readers  = '0;
    logic [OPEN_W-1:0] n_writers  = '0;
    logic              is_shut    = 1'b0;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic pipe_rsp_t pipe_apply_event(pipe_req_t r);
        pipe_rsp_t rsp;
        rsp.read_byte = '0;
        rsp.status    = ST_OK;
        rsp.last      = r.last;
        case (r.func)
            FUNC_WRITE:
            begin
                if (is_shut || n_readers == '0)
                    rsp.status = ST_BROKEN;
                else if (held_bytes >= DEPTH)
                    rsp.status = ST_BLOCK;
                else
                begin
                    buf_mem[tail_ptr] = r.write_byte;
                    tail_ptr = ptr_inc(tail_ptr);
                    held_bytes++;
                end
            end
            FUNC_READ:
            begin
                if (held_bytes > 0)
                begin
                    rsp.read_byte = buf_mem[head_ptr];
                    head_ptr = ptr_inc(head_ptr);
                    held_bytes--;
                end
                else if (n_writers != '0 && !is_shut)
                    rsp.status = ST_BLOCK;
                else
                    rsp.status = ST_EOD;
            end
            FUNC_OPEN:
            begin
                if (r.end_is_read)
                begin
                    if (n_readers != OPEN_MAX)
                        n_readers++;
                end
                else if (n_writers != OPEN_MAX)
                    n_writers++;
            end
            FUNC_CLOSE:
            begin
                if (r.end_is_read)
                begin
                    if (n_readers != '0)
                        n_readers--;
                end
                else if (n_writers != '0)
                    n_writers--;
                if (n_readers == '0 && n_writers == '0)
                    is_shut = 1'b1;
            end
            FUNC_SHUTDOWN:
                is_shut = 1'b1;
            default:
                ;
        endcase
        rsp.fill = FILL_W'(held_bytes);
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------------
    pipe_req_t pending_reqs [$];
    pipe_rsp_t expected_rsps [$];
    pipe_req_t cur_req;

    // endpoint tallies as the queued requests will leave them
    int gen_readers = 0;
    int gen_writers = 0;
    int gap_now     = 0;

    task automatic push_req(logic [2:0] f, logic [7:0] b, logic e, logic l);
        pipe_req_t r;
        r.func        = f;
        r.write_byte  = b;
        r.end_is_read = e;
        r.last        = l;
        r.gap_pct     = gap_now;
        pending_reqs.push_back(r);
        if (f == FUNC_OPEN)
        begin
            if (e && gen_readers < int'(OPEN_MAX))
                gen_readers++;
            else if (!e && gen_writers < int'(OPEN_MAX))
                gen_writers++;
        end
        else if (f == FUNC_CLOSE)
        begin
            if (e && gen_readers > 0)
                gen_readers--;
            else if (!e && gen_writers > 0)
                gen_writers--;
        end
    endtask

    // a close that leaves at least one endpoint open
    function automatic bit close_is_safe(logic e);
        if (e)
            return (gen_writers > 0) || (gen_readers > 1);
        return (gen_readers > 0) || (gen_writers > 1);
    endfunction

    task automatic push_noise(bit guarded);
        logic [2:0] f;
        logic       e;
        f = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_WRITE));
        e = 1'($urandom);
        if (guarded && (f == FUNC_SHUTDOWN || (f == FUNC_CLOSE && !close_is_safe(e))))
            f = FUNC_OPEN;
        push_req(f, 8'($urandom), e, 1'($urandom));
    endtask

    task automatic build_directed();
        gap_now = 0;
        push_req(FUNC_READ,  8'h00, 1'b0, 1'b0);  // empty, no writer: end of data
        push_req(FUNC_WRITE, 8'hFF, 1'b0, 1'b1);  // no reader: broken
        push_req(FUNC_OPEN,  8'h00, 1'b1, 1'b0);
        push_req(FUNC_OPEN,  8'hFF, 1'b0, 1'b1);
        push_req(FUNC_READ,  8'hFF, 1'b1, 1'b0);  // empty with writer: would block
        push_req(FUNC_WRITE, 8'h00, 1'b0, 1'b0);
        push_req(FUNC_WRITE, 8'hFF, 1'b1, 1'b0);
        push_req(FUNC_WRITE, 8'h5A, 1'b0, 1'b1);
        repeat (3)
            push_req(FUNC_READ, 8'($urandom), 1'($urandom), 1'($urandom));
        push_req(FUNC_READ, 8'h00, 1'b0, 1'b1);
        for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
            push_req(3'(f), 8'($urandom), 1'($urandom), 1'($urandom));
        push_req(FUNC_CLOSE, 8'h00, 1'b0, 1'b0);  // reader stays, no shutdown
        push_req(FUNC_READ,  8'h00, 1'b0, 1'b0);  // no writer left: end of data
        push_req(FUNC_WRITE, 8'hC3, 1'b0, 1'b1);
        push_req(FUNC_OPEN,  8'h00, 1'b0, 1'b0);
        push_req(FUNC_CLOSE, 8'h00, 1'b1, 1'b0);  // writer stays, no shutdown
        push_req(FUNC_WRITE, 8'h3C, 1'b1, 1'b0);  // no reader: broken
        push_req(FUNC_READ,  8'h00, 1'b0, 1'b1);  // stored byte still readable
        push_req(FUNC_OPEN,  8'h00, 1'b1, 1'b1);
    endtask

    task automatic build_random_phase(int gap);
        int   n;
        int   pick;
        int   issued;
        logic e;
        issued = 0;
        while (issued < RAND_PER_PHASE)
        begin
            gap_now = ($urandom_range(3, 0) == 0) ? 0 : gap;
            pick = $urandom_range(99, 0);
            n = ($urandom_range(7, 0) == 0) ? $urandom_range(48, 16) : $urandom_range(12, 1);
            if (pick < 40)
            begin
                for (int i = 0; i < n; i++)
                    push_req(FUNC_WRITE, 8'($urandom), 1'($urandom), i == n - 1);
            end
            else if (pick < 75)
            begin
                for (int i = 0; i < n; i++)
                    push_req(FUNC_READ, 8'($urandom), 1'($urandom), i == n - 1);
            end
            else if (pick < 88)
            begin
                n = 1;
                e = 1'($urandom);
                if ($urandom_range(1, 0) == 0 || !close_is_safe(e))
                    push_req(FUNC_OPEN, 8'($urandom), e, 1'($urandom));
                else
                    push_req(FUNC_CLOSE, 8'($urandom), e, 1'($urandom));
            end
            else
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                    push_noise(1'b1);
            end
            issued += n;
        end
    endtask

    task automatic build_saturate();
        gap_now = 0;
        if (gen_readers == 0)
            push_req(FUNC_OPEN, 8'h00, 1'b1, 1'b0);
        if (gen_writers == 0)
            push_req(FUNC_OPEN, 8'h00, 1'b0, 1'b0);
        // counts stick at the maximum, so fewer closes than opens reach zero
        repeat (int'(OPEN_MAX) + 3)
            push_req(FUNC_OPEN, 8'($urandom), 1'b1, 1'($urandom));
        repeat (int'(OPEN_MAX) + 1)
            push_req(FUNC_CLOSE, 8'($urandom), 1'b1, 1'($urandom));
        push_req(FUNC_WRITE, 8'($urandom), 1'b0, 1'b1);
        push_req(FUNC_OPEN, 8'h00, 1'b1, 1'b0);
    endtask

    task automatic build_shutdown();
        gap_now = 0;
        if (gen_readers == 0)
            push_req(FUNC_OPEN, 8'h00, 1'b1, 1'b0);
        if (gen_writers == 0)
            push_req(FUNC_OPEN, 8'h00, 1'b0, 1'b0);
        repeat (5)
            push_req(FUNC_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
        // last close of both ends raises the shutdown flag
        while (gen_readers > 0)
            push_req(FUNC_CLOSE, 8'($urandom), 1'b1, 1'($urandom));
        while (gen_writers > 0)
            push_req(FUNC_CLOSE, 8'($urandom), 1'b0, 1'($urandom));
        push_req(FUNC_OPEN, 8'h00, 1'b1, 1'b0);
        push_req(FUNC_OPEN, 8'h00, 1'b0, 1'b0);
        push_req(FUNC_WRITE, 8'hA5, 1'b0, 1'b1);  // reopen does not clear shutdown
        repeat (FINAL_READS)
            push_req(FUNC_READ, 8'($urandom), 1'($urandom), 1'($urandom));
        push_req(FUNC_SHUTDOWN, 8'($urandom), 1'($urandom), 1'($urandom));
        gap_now = 29;
        repeat (30)
            push_noise(1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            func         <= FUNC_WRITE;
            write_byte   <= '0;
            end_is_read  <= 1'b0;
            last_in_call <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
                expected_rsps.push_back(pipe_apply_event(cur_req));
            if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= pending_reqs[0].gap_pct)
            begin
                cur_req = pending_reqs.pop_front();
                start        <= 1'b1;
                func         <= cur_req.func;
                write_byte   <= cur_req.write_byte;
                end_is_read  <= cur_req.end_is_read;
                last_in_call <= cur_req.last;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and checking
    // ------------------------------------------------------------------------
    int n_errors = 0;

    task automatic report_mismatch(string what);
        n_errors++;
        // later mismatches are counted but not printed
        if (n_errors <= PRINT_LIMIT)
            $display("%0t ERROR: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : rsp_check
        pipe_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch("done with no request outstanding");
            else
            begin
                want = expected_rsps.pop_front();
                if (read_byte !== want.read_byte)
                    report_mismatch($sformatf("read_byte got %02h want %02h",
                                              read_byte, want.read_byte));
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", status, want.status));
                if (last !== want.last)
                    report_mismatch($sformatf("last got %b want %b", last, want.last));
                if (fill_level !== want.fill)
                    report_mismatch($sformatf("fill_level got %0d want %0d",
                                              fill_level, want.fill));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with neither a request taken nor a response
    // ------------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WDOG_LIMIT)
        begin
            $display("pipe_byte_fifo_core test failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        build_directed();
        build_random_phase(0);
        build_saturate();
        build_random_phase(81);
        build_random_phase(29);
        build_shutdown();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0 && expected_rsps.size() == 0)
            $display("pipe_byte_fifo_core test passed");
        else
            $display("pipe_byte_fifo_core test failed");
        $finish;
    end

endmodule
